// ===== rtl/rfm_pkg.sv =====
// Shared types and constants for the reciprocal frequency meter.
// No dependencies; used by reciprocal_frequency_meter_unit.
`timescale 1ns / 1ps
`default_nettype none

package rfm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // Capture counter clock after prescaling, value after reset
  localparam logic [DATA_W-1:0] CLK_RATE_RST = 32'd1000000;

  // Rollovers without a capture saturate here; above one forces zero frequency
  localparam logic [1:0] ROLL_MAX    = 2'd2;
  localparam logic [1:0] ROLL_FORCE0 = 2'd2;

  // Event kinds carried on in_tuser
  typedef enum logic {
    REQ_CAPTURE  = 1'b0,
    REQ_ROLLOVER = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/reciprocal_frequency_meter_unit.sv =====
// Reciprocal frequency meter: capture / rollover events in, frequency words out.
// A capture runs through the divide state (the restoring divider) and then the finish
// state, which loads the output register; a rollover goes straight to the finish state.
// One event is in work at a time; an output stall holds the finish state.
// The restoring divider yields one quotient bit per cycle.
// Reset (rst_n low, synchronous): clock rate back to 1 MHz, state cleared, no output.
`timescale 1ns / 1ps
`default_nettype none

module reciprocal_frequency_meter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: clock_rate_hz
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // event channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        in_tuser,   // [0] req_type
  input  wire logic [31:0] in_tdata,   // [31:0] capture_value
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [31:0] frequency
);

  localparam int unsigned W = rfm_pkg::DATA_W;

  rfm_pkg::state_t state_r, state_nxt;

  logic [W-1:0]             clk_rate_r;
  logic [W-1:0]             prev_cap_r, prev_cap_nxt;
  logic [W-1:0]             freq_r, freq_nxt;
  logic [1:0]               roll_cnt_r, roll_cnt_nxt;
  logic [W-1:0]             den_r, den_nxt;
  logic [W-1:0]             quo_r, quo_nxt;
  logic [W-1:0]             rem_r, rem_nxt;
  logic [rfm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [W-1:0]             out_data_r, out_data_nxt;

  logic         in_acc;
  logic         div_step;
  logic         load_out;
  logic         out_free;
  logic [W:0]   trial;
  logic [1:0]   roll_inc;

  assign in_acc   = in_tvalid & in_tready;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rfm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (rfm_pkg::req_type_t'(in_tuser) == rfm_pkg::REQ_CAPTURE) begin
            state_nxt = rfm_pkg::ST_DIV;
          end else begin
            state_nxt = rfm_pkg::ST_FIN;
          end
        end
      end
      rfm_pkg::ST_DIV: begin
        if (cnt_r == rfm_pkg::CNT_W'(W - 1)) begin
          state_nxt = rfm_pkg::ST_FIN;
        end
      end
      rfm_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = rfm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rfm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_step  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      rfm_pkg::ST_IDLE: in_tready = 1'b1;
      rfm_pkg::ST_DIV:  div_step  = 1'b1;
      rfm_pkg::ST_FIN:  load_out  = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem_r, quo_r[W-1]} - {1'b0, den_r};
  assign roll_inc = (roll_cnt_r < rfm_pkg::ROLL_MAX) ? roll_cnt_r + 2'd1 : roll_cnt_r;

  always_comb begin
    prev_cap_nxt  = prev_cap_r;
    freq_nxt      = freq_r;
    roll_cnt_nxt  = roll_cnt_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      if (rfm_pkg::req_type_t'(in_tuser) == rfm_pkg::REQ_CAPTURE) begin
        // wrapped distance is one short of the modular difference
        if (in_tdata > prev_cap_r) begin
          den_nxt = in_tdata - prev_cap_r;
        end else begin
          den_nxt = in_tdata - prev_cap_r - W'(1);
        end
        quo_nxt      = clk_rate_r;
        rem_nxt      = '0;
        cnt_nxt      = '0;
        prev_cap_nxt = in_tdata;
        roll_cnt_nxt = 2'd0;
      end else begin
        roll_cnt_nxt = roll_inc;
        if (roll_inc >= rfm_pkg::ROLL_FORCE0) begin
          freq_nxt = '0;
        end
      end
    end

    if (div_step) begin
      cnt_nxt = cnt_r + rfm_pkg::CNT_W'(1);
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      if (cnt_r == rfm_pkg::CNT_W'(W - 1)) begin
        freq_nxt = quo_nxt;
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = freq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfm_pkg::ST_IDLE;
      clk_rate_r  <= rfm_pkg::CLK_RATE_RST;
      prev_cap_r  <= '0;
      freq_r      <= '0;
      roll_cnt_r  <= 2'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_cap_r  <= prev_cap_nxt;
      freq_r      <= freq_nxt;
      roll_cnt_r  <= roll_cnt_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        clk_rate_r <= cfg_wdata;
      end
    end
  end

  // datapath words, no reset
  always_ff @(posedge clk) begin
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    roll_cnt_r != 2'd3)
    else $error("rollover count out of range");

  a_roll_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_cnt_r == rfm_pkg::ROLL_FORCE0) |-> (freq_r == '0))
    else $error("frequency not zero after repeated rollover");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rfm_pkg::ST_DIV) |-> (cnt_r == '0))
    else $error("divider step count left nonzero");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == rfm_pkg::ST_FIN))
    else $error("output word raised outside finish state");

endmodule

`default_nettype wire
